// File: hdl/csvt_pkg.sv
package csvt_pkg;

    // Design constants
    localparam int MAX_SEPARATORS = 4;
    localparam int COLUMN_BITS    = 16;
    localparam int SEP_REGS       = 4;
    localparam int SEP_LIMIT      = (MAX_SEPARATORS < SEP_REGS) ? MAX_SEPARATORS : SEP_REGS;

    // Field widths
    localparam int BYTE_W      = 8;
    localparam int SEP_COUNT_W = 3;
    localparam int COL_IDX_W   = 16;
    localparam int ROW_W       = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    // Characters
    localparam logic [BYTE_W-1:0] CH_LF  = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_TAB = 8'h09;
    localparam logic [BYTE_W-1:0] CH_N   = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_T   = 8'h74;
    localparam logic [BYTE_W-1:0] CH_R   = 8'h72;

    // Register reset values
    localparam logic [BYTE_W-1:0]      SEP0_RESET      = 8'd59;
    localparam logic [BYTE_W-1:0]      SEPX_RESET      = 8'd0;
    localparam logic [SEP_COUNT_W-1:0] SEP_COUNT_RESET = 3'd1;
    localparam logic [BYTE_W-1:0]      QUOTE_RESET     = 8'd34;
    localparam logic [BYTE_W-1:0]      ESCAPE_RESET    = 8'd92;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SEP_CHAR_0 = 3'd0,
        CFG_SEP_CHAR_1 = 3'd1,
        CFG_SEP_CHAR_2 = 3'd2,
        CFG_SEP_CHAR_3 = 3'd3,
        CFG_SEP_COUNT  = 3'd4,
        CFG_QUOTE_CHAR = 3'd5,
        CFG_ESC_CHAR   = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MODE_PLAIN   = 3'd0,
        MODE_QUOTED  = 3'd1,
        MODE_ESCAPED = 3'd2,
        MODE_DQUOTE  = 3'd3,
        MODE_ERROR   = 3'd4
    } parse_mode_t;

endpackage

// File: hdl/csvt_if.sv
interface csvt_byte_if;
    logic                          valid;
    logic                          ready;
    logic [csvt_pkg::BYTE_W-1:0]   data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface csvt_token_if;
    logic                             valid;
    logic                             ready;
    logic                             char_valid;
    logic [csvt_pkg::BYTE_W-1:0]      char_out;
    logic                             cell_end;
    logic [csvt_pkg::COL_IDX_W-1:0]   column_index;
    logic                             row_end;
    logic [csvt_pkg::ROW_W-1:0]       row_index;
    logic [csvt_pkg::COL_IDX_W-1:0]   widest_row;
    logic                             error;

    modport source (output valid, output char_valid, output char_out, output cell_end,
                    output column_index, output row_end, output row_index,
                    output widest_row, output error, input ready);
    modport sink   (input valid, input char_valid, input char_out, input cell_end,
                    input column_index, input row_end, input row_index,
                    input widest_row, input error, output ready);
endinterface

// File: hdl/csv_byte_tokenizer_core.sv
// CSV byte tokenizer. Takes one text byte per word on byte_stream and returns exactly
// one token word per byte on token_stream: the cell character after escape translation
// (char_valid/char_out), cell and row end marks with the column and row of the ended
// cell, the widest finished row so far and a sticky error flag. A byte passes an input
// register, then compare logic updates the parse mode and the saturating column/row
// counters and loads the token register (two register stages in all).
// One byte per cycle is sustained while token_stream keeps ready high,
// since the single mode/counter update per byte is the only loop. An unknown escape
// inside quotes puts the block in an error mode that swallows all later bytes (each
// still yields a token with only error set) until reset. Registers are written through
// cfg_we/cfg_index/cfg_data and must only change while no byte is in flight.
module csv_byte_tokenizer_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [csvt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [csvt_pkg::CFG_DATA_W-1:0]     cfg_data,
    csvt_byte_if.sink                           byte_stream,
    csvt_token_if.source                        token_stream
);
    import csvt_pkg::*;

    // configuration registers
    logic [SEP_REGS-1:0][BYTE_W-1:0] sep_char_reg;
    logic [SEP_COUNT_W-1:0]          sep_count_reg;
    logic [BYTE_W-1:0]               quote_char_reg;
    logic [BYTE_W-1:0]               escape_char_reg;

    // input stage
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    // parser state
    parse_mode_t            mode_reg, mode_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [COLUMN_BITS-1:0] max_col_reg, max_col_next;
    logic [ROW_W-1:0]       row_reg, row_next;

    // token register
    logic                 out_valid_reg;
    logic                 char_valid_reg, char_valid_next;
    logic [BYTE_W-1:0]    char_out_reg, char_out_next;
    logic                 cell_end_reg, cell_end_next;
    logic [COL_IDX_W-1:0] col_idx_reg, col_idx_next;
    logic                 row_end_reg, row_end_next;
    logic [ROW_W-1:0]     row_idx_reg;
    logic [COL_IDX_W-1:0] widest_reg;
    logic                 error_reg;

    logic                   advance;
    logic                   fire;
    logic [BYTE_W-1:0]      b;
    logic                   is_quote;
    logic                   is_esc;
    logic                   is_sep;
    logic                   plain;
    logic [COLUMN_BITS-1:0] col_inc;

    // pipeline moves whenever the token register is empty or being drained
    assign advance           = !out_valid_reg || token_stream.ready;
    assign fire              = in_valid_reg && advance;
    assign byte_stream.ready = !in_valid_reg || advance;

    assign b        = in_byte_reg;
    assign is_quote = (b == quote_char_reg);
    assign is_esc   = (b == escape_char_reg);

    // only the first min(sep_count, SEP_LIMIT) separators take part
    always_comb
    begin
        is_sep = 1'b0;
        for (int i = 0; i < SEP_LIMIT; i++)
        begin
            if ((SEP_COUNT_W'(i) < sep_count_reg) && (sep_char_reg[i] == b))
            begin
                is_sep = 1'b1;
            end
        end
    end

    // unquoted handling also covers a non-quote after a closing quote
    assign plain = (mode_reg == MODE_PLAIN) || ((mode_reg == MODE_DQUOTE) && !is_quote);

    // next parse mode
    always_comb
    begin
        mode_next = mode_reg;
        case (mode_reg)
            MODE_PLAIN:
            begin
                if (is_quote)
                begin
                    mode_next = MODE_QUOTED;
                end
            end
            MODE_QUOTED:
            begin
                if (is_esc)
                begin
                    mode_next = MODE_ESCAPED;
                end
                else if (is_quote)
                begin
                    mode_next = MODE_DQUOTE;
                end
            end
            MODE_ESCAPED:
            begin
                if ((b == CH_N) || (b == CH_T) || (b == CH_R) || is_quote)
                begin
                    mode_next = MODE_QUOTED;
                end
                else
                begin
                    mode_next = MODE_ERROR;
                end
            end
            MODE_DQUOTE:
            begin
                // doubled quote stays quoted; anything else is unquoted (never a quote here)
                mode_next = is_quote ? MODE_QUOTED : MODE_PLAIN;
            end
            MODE_ERROR:
            begin
                mode_next = MODE_ERROR;
            end
            default:
            begin
                mode_next = MODE_ERROR;
            end
        endcase
    end

    // token fields
    always_comb
    begin
        char_valid_next = 1'b0;
        char_out_next   = '0;
        case (mode_reg)
            MODE_QUOTED:
            begin
                if (!is_esc && !is_quote)
                begin
                    char_valid_next = 1'b1;
                    char_out_next   = b;
                end
            end
            MODE_ESCAPED:
            begin
                if (b == CH_N)
                begin
                    char_valid_next = 1'b1;
                    char_out_next   = CH_LF;
                end
                else if (b == CH_T)
                begin
                    char_valid_next = 1'b1;
                    char_out_next   = CH_TAB;
                end
                else if (b == CH_R)
                begin
                    char_valid_next = 1'b1;
                    char_out_next   = CH_CR;
                end
                else if (is_quote)
                begin
                    char_valid_next = 1'b1;
                    char_out_next   = b;
                end
            end
            MODE_DQUOTE, MODE_PLAIN:
            begin
                if (is_quote && (mode_reg == MODE_DQUOTE))
                begin
                    char_valid_next = 1'b1;
                    char_out_next   = b;
                end
                else if (!is_quote && !is_sep && (b != CH_LF) && (b != CH_CR))
                begin
                    char_valid_next = 1'b1;
                    char_out_next   = b;
                end
            end
            default:
            begin
                char_valid_next = 1'b0;
            end
        endcase

        cell_end_next = plain && !is_quote && (is_sep || (b == CH_LF));
        row_end_next  = plain && (b == CH_LF);
        col_idx_next  = cell_end_next ? COL_IDX_W'(col_reg) : '0;
    end

    // counters, all saturating
    assign col_inc = (cell_end_next && !(&col_reg)) ? col_reg + 1'b1 : col_reg;

    always_comb
    begin
        col_next     = col_inc;
        max_col_next = max_col_reg;
        row_next     = row_reg;
        if (row_end_next)
        begin
            col_next = '0;
            if (col_inc > max_col_reg)
            begin
                max_col_next = col_inc;
            end
            if (!(&row_reg))
            begin
                row_next = row_reg + 1'b1;
            end
        end
    end

    // configuration writes; indexes beyond the list are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_char_reg[0] <= SEP0_RESET;
            for (int i = 1; i < SEP_REGS; i++)
            begin
                sep_char_reg[i] <= SEPX_RESET;
            end
            sep_count_reg   <= SEP_COUNT_RESET;
            quote_char_reg  <= QUOTE_RESET;
            escape_char_reg <= ESCAPE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEP_CHAR_0: sep_char_reg[0] <= cfg_data;
                CFG_SEP_CHAR_1: sep_char_reg[1] <= cfg_data;
                CFG_SEP_CHAR_2: sep_char_reg[2] <= cfg_data;
                CFG_SEP_CHAR_3: sep_char_reg[3] <= cfg_data;
                CFG_SEP_COUNT:  sep_count_reg   <= cfg_data[SEP_COUNT_W-1:0];
                CFG_QUOTE_CHAR: quote_char_reg  <= cfg_data;
                CFG_ESC_CHAR:   escape_char_reg <= cfg_data;
                default:        sep_count_reg   <= sep_count_reg;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_PLAIN;
            col_reg       <= '0;
            max_col_reg   <= '0;
            row_reg       <= '0;
        end
        else
        begin
            if (byte_stream.ready)
            begin
                in_valid_reg <= byte_stream.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire)
            begin
                mode_reg    <= mode_next;
                col_reg     <= col_next;
                max_col_reg <= max_col_next;
                row_reg     <= row_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (byte_stream.ready && byte_stream.valid)
        begin
            in_byte_reg <= byte_stream.data_byte;
        end
        if (fire)
        begin
            char_valid_reg <= char_valid_next;
            char_out_reg   <= char_out_next;
            cell_end_reg   <= cell_end_next;
            col_idx_reg    <= col_idx_next;
            row_end_reg    <= row_end_next;
            row_idx_reg    <= row_reg;
            widest_reg     <= COL_IDX_W'(max_col_next);
            error_reg      <= (mode_next == MODE_ERROR);
        end
    end

    assign token_stream.valid        = out_valid_reg;
    assign token_stream.char_valid   = char_valid_reg;
    assign token_stream.char_out     = char_out_reg;
    assign token_stream.cell_end     = cell_end_reg;
    assign token_stream.column_index = col_idx_reg;
    assign token_stream.row_end      = row_end_reg;
    assign token_stream.row_index    = row_idx_reg;
    assign token_stream.widest_row   = widest_reg;
    assign token_stream.error        = error_reg;

`ifndef SYNTHESIS
    // a character and a cell/row end never come from the same byte
    a_char_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && char_valid_reg |-> !cell_end_reg && !row_end_reg)
        else $error("char and end mark in one token");

    // error mode never leaves until reset
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_ERROR |=> mode_reg == MODE_ERROR)
        else $error("left error mode");

    // an erroring token carries nothing else
    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && error_reg |-> !char_valid_reg && !cell_end_reg && !row_end_reg)
        else $error("token content in error mode");

    // widest row only grows
    a_widest_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> max_col_reg >= $past(max_col_reg))
        else $error("widest row shrank");

    // column index only meaningful with a cell end
    a_col_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !cell_end_reg |-> col_idx_reg == '0)
        else $error("column index without cell end");
`endif

endmodule

// File: bench/tb_csv_byte_tokenizer_core.sv
`timescale 1ns / 100ps

module tb_csv_byte_tokenizer_core;

    import csvt_pkg::*;

    localparam int CLK_HALF_NS = 5;
    localparam int TIMEOUT_NS  = 1_000_000;   // far above a full run
    localparam int DRAIN_LIMIT = 2000;        // cycles to wait for outstanding tokens
    localparam int IDLE_PCT    = 22;

    // One token word, laid out field by field as on token_stream.
    typedef struct packed {
        logic                 char_valid;
        logic [BYTE_W-1:0]    char_out;
        logic                 cell_end;
        logic [COL_IDX_W-1:0] column_index;
        logic                 row_end;
        logic [ROW_W-1:0]     row_index;
        logic [COL_IDX_W-1:0] widest_row;
        logic                 error;
    } token_t;

    // Scoreboard: keeps its own tokenizer state and register copy, turns every
    // accepted byte into the expected token word and checks tokens in order.
    class token_scoreboard;
        token_t               pending_tokens[$];
        parse_mode_t          mode;
        logic [COL_IDX_W-1:0] col_cnt;
        logic [COL_IDX_W-1:0] widest;
        logic [ROW_W-1:0]     row_cnt;
        logic [BYTE_W-1:0]    sep[SEP_REGS];
        logic [SEP_COUNT_W-1:0] sep_cnt;
        logic [BYTE_W-1:0]    quote;
        logic [BYTE_W-1:0]    esc;
        int                   errors;
        int                   checked;

        function new();
            mode    = MODE_PLAIN;
            col_cnt = '0;
            widest  = '0;
            row_cnt = '0;
            sep[0]  = SEP0_RESET;
            for (int i = 1; i < SEP_REGS; i++)
                sep[i] = SEPX_RESET;
            sep_cnt = SEP_COUNT_RESET;
            quote   = QUOTE_RESET;
            esc     = ESCAPE_RESET;
            errors  = 0;
            checked = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_SEP_CHAR_0: sep[0]  = v;
                CFG_SEP_CHAR_1: sep[1]  = v;
                CFG_SEP_CHAR_2: sep[2]  = v;
                CFG_SEP_CHAR_3: sep[3]  = v;
                CFG_SEP_COUNT:  sep_cnt = v[SEP_COUNT_W-1:0];
                CFG_QUOTE_CHAR: quote   = v;
                CFG_ESC_CHAR:   esc     = v;
                default: ;
            endcase
        endfunction

        function int active_seps();
            return (sep_cnt > SEP_LIMIT) ? SEP_LIMIT : int'(sep_cnt);
        endfunction

        function bit is_sep(logic [BYTE_W-1:0] b);
            int n;
            n = active_seps();
            for (int i = 0; i < n; i++)
                if (sep[i] == b)
                    return 1'b1;
            return 1'b0;
        endfunction

        // Next-state and token for one byte.
        function token_t tokenize(logic [BYTE_W-1:0] b);
            token_t t;
            bit     plain;
            t           = '0;
            t.row_index = row_cnt;
            plain       = 1'b0;
            case (mode)
                MODE_QUOTED:
                    if (b == esc)
                        mode = MODE_ESCAPED;
                    else if (b == quote)
                        mode = MODE_DQUOTE;
                    else
                    begin
                        t.char_valid = 1'b1;
                        t.char_out   = b;
                    end
                MODE_ESCAPED:
                begin
                    mode         = MODE_QUOTED;
                    t.char_valid = 1'b1;
                    if (b == CH_N)
                        t.char_out = CH_LF;
                    else if (b == CH_T)
                        t.char_out = CH_TAB;
                    else if (b == CH_R)
                        t.char_out = CH_CR;
                    else if (b == quote)
                        t.char_out = b;
                    else
                    begin
                        t.char_valid = 1'b0;
                        mode         = MODE_ERROR;
                    end
                end
                MODE_DQUOTE:
                    if (b == quote)
                    begin
                        t.char_valid = 1'b1;
                        t.char_out   = b;
                        mode         = MODE_QUOTED;
                    end
                    else
                    begin
                        mode  = MODE_PLAIN;
                        plain = 1'b1;
                    end
                MODE_PLAIN:
                    plain = 1'b1;
                default:
                    mode = MODE_ERROR;
            endcase

            if (plain)
            begin
                if (b == quote)
                    mode = MODE_QUOTED;
                else if (is_sep(b) || b == CH_LF)
                begin
                    t.cell_end     = 1'b1;
                    t.column_index = col_cnt;
                    if (col_cnt != '1)
                        col_cnt++;
                end
                else if (b != CH_CR)
                begin
                    t.char_valid = 1'b1;
                    t.char_out   = b;
                end
                if (b == CH_LF)
                begin
                    t.row_end = 1'b1;
                    if (col_cnt > widest)
                        widest = col_cnt;
                    col_cnt = '0;
                    if (row_cnt != '1)
                        row_cnt++;
                end
            end

            t.widest_row = widest;
            t.error      = (mode == MODE_ERROR);
            return t;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            pending_tokens = {pending_tokens, tokenize(b)};
        endfunction

        function int pending();
            return pending_tokens.size();
        endfunction

        task report(string msg);
            errors++;
            $display("MISMATCH @%0t token %0d: %s", $time, checked, msg);
        endtask

        task cmp_field(string name, logic [ROW_W-1:0] got, logic [ROW_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check(token_t got);
            token_t want;
            if (pending_tokens.size() == 0)
            begin
                report($sformatf("token word with nothing expected: %p", got));
            end
            else
            begin
                want = pending_tokens.pop_front();
                cmp_field("char_valid",   got.char_valid,   want.char_valid);
                cmp_field("char_out",     got.char_out,     want.char_out);
                cmp_field("cell_end",     got.cell_end,     want.cell_end);
                cmp_field("column_index", got.column_index, want.column_index);
                cmp_field("row_end",      got.row_end,      want.row_end);
                cmp_field("row_index",    got.row_index,    want.row_index);
                cmp_field("widest_row",   got.widest_row,   want.widest_row);
                cmp_field("error",        got.error,        want.error);
            end
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    csvt_byte_if  byte_if();
    csvt_token_if token_if();

    token_scoreboard sb = new();

    bit quiet;       // no idling on either side while set
    int bytes_sent;

    csv_byte_tokenizer_core u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_stream  (byte_if),
        .token_stream (token_if)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF_NS clk = ~clk;

    // Monitor and token sink in one process: the byte word accepted at an edge
    // is noted before any token checked at the same edge, whatever the order
    // of processes. Ready is redrawn every cycle.
    always @(posedge clk)
    begin
        token_t got;
        if (rst_n)
        begin
            if (byte_if.valid && byte_if.ready)
                sb.note_byte(byte_if.data_byte);
            if (token_if.valid && token_if.ready)
            begin
                got.char_valid   = token_if.char_valid;
                got.char_out     = token_if.char_out;
                got.cell_end     = token_if.cell_end;
                got.column_index = token_if.column_index;
                got.row_end      = token_if.row_end;
                got.row_index    = token_if.row_index;
                got.widest_row   = token_if.widest_row;
                got.error        = token_if.error;
                sb.check(got);
            end
        end
        token_if.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end

    // Register write: cfg_we is high for a single cycle and then driven low, so that
    // back-to-back writes never drive cfg_we twice in one step.
    task write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        sb.set_reg(idx, v);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task set_config(logic [BYTE_W-1:0] s0, logic [BYTE_W-1:0] s1, logic [BYTE_W-1:0] s2,
                    logic [BYTE_W-1:0] s3, logic [SEP_COUNT_W-1:0] cnt,
                    logic [BYTE_W-1:0] q, logic [BYTE_W-1:0] e);
        write_reg(CFG_SEP_CHAR_0, s0);
        write_reg(CFG_SEP_CHAR_1, s1);
        write_reg(CFG_SEP_CHAR_2, s2);
        write_reg(CFG_SEP_CHAR_3, s3);
        write_reg(CFG_SEP_COUNT, CFG_DATA_W'(cnt));
        write_reg(CFG_QUOTE_CHAR, q);
        write_reg(CFG_ESC_CHAR, e);
    endtask

    // Random registers. The escape char is kept apart from the quote, the
    // separators, CR and LF, so a structural byte never starts an escape and
    // the sticky error mode is only entered on purpose at the end.
    task random_config();
        logic [BYTE_W-1:0] s[SEP_REGS];
        logic [BYTE_W-1:0] q;
        logic [BYTE_W-1:0] e;
        bit clash;
        foreach (s[i])
            s[i] = BYTE_W'($urandom_range(255));
        q = BYTE_W'($urandom_range(255));
        do
        begin
            e = BYTE_W'($urandom_range(255));
            clash = (e == q) || (e == CH_LF) || (e == CH_CR);
            foreach (s[i])
                if (s[i] == e)
                    clash = 1'b1;
        end
        while (clash);
        set_config(s[0], s[1], s[2], s[3], SEP_COUNT_W'($urandom_range(7)), q, e);
    endtask

    // One byte word. valid stays high across back-to-back words; it only
    // drops when an idle cycle is drawn.
    task send_byte(logic [BYTE_W-1:0] b);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            byte_if.valid <= 1'b0;
            @(posedge clk);
        end
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        @(posedge clk);
        while (!byte_if.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Content byte: never the escape char (so escapes are always well formed),
    // and never the quote unless noise is asked for.
    function logic [BYTE_W-1:0] content_byte(bit noise);
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(255));
        while (b == sb.esc || (!noise && b == sb.quote));
        return b;
    endfunction

    // One cell plus its terminator: mostly plain or quoted cells with random
    // content, escapes and doubled quotes; now and then raw noise.
    task send_cell();
        int kind;
        int len;
        int n;
        kind = $urandom_range(9);
        if (kind == 0)
        begin
            len = $urandom_range(4, 1);
            repeat (len)
                send_byte(content_byte(1'b1));
        end
        else if (kind <= 4)
        begin
            len = $urandom_range(5);
            repeat (len)
                send_byte(content_byte(1'b0));
        end
        else
        begin
            send_byte(sb.quote);
            len = $urandom_range(6);
            repeat (len)
            begin
                case ($urandom_range(9))
                    0, 1:
                    begin
                        send_byte(sb.esc);
                        case ($urandom_range(3))
                            0: send_byte(CH_N);
                            1: send_byte(CH_T);
                            2: send_byte(CH_R);
                            default: send_byte(sb.quote);
                        endcase
                    end
                    2:
                    begin
                        send_byte(sb.quote);  // doubled quote
                        send_byte(sb.quote);
                    end
                    default: send_byte(content_byte(1'b0));
                endcase
            end
            send_byte(sb.quote);
        end

        n = sb.active_seps();
        if (n > 0 && $urandom_range(3) != 0)
            send_byte(sb.sep[$urandom_range(n - 1)]);
        else
        begin
            if ($urandom_range(1))
                send_byte(CH_CR);
            send_byte(CH_LF);
        end
    endtask

    task send_records(int count);
        int target;
        target = bytes_sent + count;
        while (bytes_sent < target)
            send_cell();
    endtask

    // Let every expected token word come out; registers only change after this.
    task wait_idle();
        int n;
        n = 0;
        byte_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (4)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_SEP_CHAR_0;
        cfg_data           = '0;
        byte_if.valid      = 1'b0;
        byte_if.data_byte  = '0;
        token_if.ready     = 1'b0;
        quiet              = 1'b0;
        bytes_sent         = 0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset registers: plain cells, quoted separator, doubled quote, all
        // four escapes, a byte right after a closing quote, 00/FF, dropped CR,
        // LF ending cell and row, quote closed straight into LF, empty row.
        send_text("ab;\";\"\"\\n\\t\\r\\\"\"x;");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_CR);
        send_byte(CH_LF);
        send_text("\"q\"\n\n");
        send_records(150);
        wait_idle();

        // All four separators in use, byte extremes as separators.
        set_config(8'h00, 8'hFF, ",", CH_TAB, 3'd4, "'", "!");
        send_records(150);
        wait_idle();

        // No separators, LF as quote: a row end also opens quotes. Long
        // stretch with no idling on either side.
        quiet = 1'b1;
        set_config(";", "|", 8'h00, 8'hFF, 3'd0, CH_LF, 8'hFF);
        send_records(150);
        wait_idle();
        quiet = 1'b0;

        // Count above the separator limit, quote 00, escape 'n'.
        set_config(",", ";", 8'hFF, 8'h00, 3'd7, 8'h00, "n");
        send_records(150);
        wait_idle();

        repeat (2)
        begin
            random_config();
            send_records(150);
            wait_idle();
        end

        // Back to the reset registers for the error case.
        set_config(";", 8'h00, 8'h00, 8'h00, 3'd1, "\"", "\\");
        send_records(50);
        wait_idle();

        // Unknown escape: sticky error, everything after it is swallowed.
        send_text("\"\\x");
        repeat (24)
            send_byte(BYTE_W'($urandom_range(255)));
        send_byte(CH_LF);
        wait_idle();

        if (sb.pending() != 0)
            sb.report($sformatf("%0d token words never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("tb_csv_byte_tokenizer_core passed");
        else
            $display("tb_csv_byte_tokenizer_core failed");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_csv_byte_tokenizer_core failed");
        $finish;
    end

endmodule
